/* src/parity_union_find_core_macros.svh */
// ---------------------------------------------------------------------------
// parity_union_find_core_macros.svh
// Assertion helpers for the parity union-find core.
// ---------------------------------------------------------------------------
`ifndef PARITY_UNION_FIND_CORE_MACROS_SVH
`define PARITY_UNION_FIND_CORE_MACROS_SVH

// same-cycle implication, quiet during reset
`define PUFC_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define PUFC_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/pufc_pkg.sv */
// ---------------------------------------------------------------------------
// pufc_pkg
// Types and constants shared by the parity union-find core.
// ---------------------------------------------------------------------------
package pufc_pkg;

	localparam int NODE_W   = 10;
	localparam int CMD_W    = 2;
	localparam int CFG_W    = 11;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 11'd1024;

	// register index, taken from paddr[2]
	localparam logic REG_NODE_COUNT = 1'b0;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNION = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] root_a;
		logic              parity_a;
		logic [NODE_W-1:0] root_b;
		logic              parity_b;
		logic              same_set;
		logic              error;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_WALK_REQ,
		ST_WALK_CHK,
		ST_COMP_REQ,
		ST_COMP_CHK,
		ST_UNION
	} state_t;

endpackage

/* src/parity_union_find_core.sv */
// ---------------------------------------------------------------------------
// parity_union_find_core
// Disjoint-set forest with per-node parity, path compression and an APB
// register for the number of nodes in use.
// ---------------------------------------------------------------------------
// Usage:
//   Present a command on req and raise start; it is taken at the clock edge
//   where start is high and busy is low. Exactly one result follows per item
//   on rsp, marked by done for a single cycle; the receiver cannot stall it,
//   so capture it when done is high.
//   Clear holds busy high while it writes every node in use (node_count, capped
//   at NODES), one RAM write each, and its result comes as busy falls. An
//   empty clear or an error result comes in the cycle after the item is taken.
//   Find and union hold busy high while, for each of the two nodes in turn,
//   the single RAM read port walks the parent links to the root, fetching
//   one link a cycle, and then compresses the path, fetching one link a
//   cycle again and writing back one node a cycle. The result comes as busy
//   falls, but a union with distinct roots holds busy high through ST_UNION
//   for the root link write after its result.
//   After reset busy stays high while the RAM is swept to singletons of
//   parity 0; node_count returns to 1024. Write node_count only while the
//   core is idle and no result is pending.
// ---------------------------------------------------------------------------
`include "parity_union_find_core_macros.svh"

module parity_union_find_core import pufc_pkg::*; #(
	parameter int NODES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp
);

	localparam int CW  = $clog2(NODES + 1);
	localparam int CMW = (CW > CFG_W) ? CW : CFG_W;

	logic [CFG_W-1:0] node_count_q;
	logic [CW-1:0]    lim;
	logic             reg_sel;

	assign reg_sel = (paddr[ADDR_W-1] == REG_NODE_COUNT);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? DATA_W'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			node_count_q <= pwdata[CFG_W-1:0];
		end
	end

	// saturate the count to the RAM depth
	assign lim = (CMW'(node_count_q) > CMW'(NODES)) ? CW'(NODES) : CW'(node_count_q);

	pufc_engine #(
		.NODES(NODES)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.lim   (lim),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	`PUFC_CHECK_NOW(a_err_fields_zero, done && rsp.error, (rsp.root_a == '0) && (rsp.root_b == '0) && !rsp.same_set && !rsp.parity_a && !rsp.parity_b, "error result carries nonzero fields")
	`PUFC_CHECK_NOW(a_same_set_match, done && rsp.same_set, rsp.root_a == rsp.root_b, "same_set disagrees with roots")
	`PUFC_CHECK_NOW(a_done_has_item, done, $past(busy) || $past(start), "result without an item in flight")
	`PUFC_CHECK_NEXT(a_walk_holds_busy, start && !busy && (req.command == CMD_FIND) && (req.node_a < node_count_q[NODE_W-1:0]) && (req.node_b < node_count_q[NODE_W-1:0]) && (node_count_q <= CFG_W'(NODES)) && !node_count_q[CFG_W-1], busy && !done, "find did not enter the walk")

endmodule

/* src/pufc_ram.sv */
// ---------------------------------------------------------------------------
// pufc_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module pufc_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/pufc_engine.sv */
// ---------------------------------------------------------------------------
// pufc_engine
// Command sequencer: walks parent links in the node RAM, compresses paths,
// links roots on union and sweeps the RAM on clear and after reset.
// ---------------------------------------------------------------------------
module pufc_engine import pufc_pkg::*; #(
	parameter int NODES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(NODES+1)-1:0] lim,
	input  logic                       start,
	output logic                       busy,
	input  req_t                       req,
	output logic                       done,
	output rsp_t                       rsp
);

	localparam int AW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam int EW = (CW > NODE_W) ? CW : NODE_W;

	state_t state_q, state_d;

	logic [CW-1:0]    cnt_q;
	logic             side_q;
	logic [CMD_W-1:0] cmd_q;
	logic [AW-1:0]    node_b_q;
	logic [AW-1:0]    node_q;
	logic [AW-1:0]    cur_q;
	logic [AW-1:0]    root_q;
	logic             acc_q;
	logic             p_q;
	logic [AW-1:0]    ra_q;
	logic             pa_q;
	logic             done_q;
	rsp_t             rsp_q;

	// RAM word: {parity, parent}
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW:0]   wdata;
	logic [AW-1:0] raddr;
	logic [AW:0]   rdata;
	logic [AW-1:0] rd_node;
	logic          rd_par;

	logic          in_range;
	logic          cmd_ok;
	logic          at_root;
	logic          comp_last;
	logic          find_end;
	logic [AW-1:0] fin_root;
	logic          do_union;
	logic          init_last;
	logic          clear_last;

	pufc_ram #(
		.WIDTH(AW + 1),
		.DEPTH(NODES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_node = rdata[AW-1:0];
	assign rd_par  = rdata[AW];

	assign in_range = (EW'(req.node_a) < EW'(lim)) && (EW'(req.node_b) < EW'(lim));
	assign cmd_ok   = req.command inside {CMD_FIND, CMD_UNION};

	assign at_root   = (rd_node == cur_q);
	assign comp_last = (rd_node == root_q);
	assign find_end  = ((state_q == ST_WALK_CHK) && at_root && (cur_q == node_q)) ||
	                   ((state_q == ST_COMP_CHK) && comp_last);
	assign fin_root  = (state_q == ST_WALK_CHK) ? cur_q : root_q;
	assign do_union  = (cmd_q == CMD_UNION) && (ra_q != fin_root);

	assign init_last  = (cnt_q == CW'(NODES - 1));
	assign clear_last = ((cnt_q + CW'(1)) == lim);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (req.command == CMD_CLEAR) begin
						if (lim != '0) begin
							state_d = ST_CLEAR;
						end
					end else if (cmd_ok && in_range) begin
						state_d = ST_WALK_REQ;
					end
				end
			end
			ST_CLEAR: begin
				if (clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK_REQ: state_d = ST_WALK_CHK;
			ST_WALK_CHK: begin
				if (at_root && (cur_q != node_q)) begin
					state_d = ST_COMP_REQ;
				end
			end
			ST_COMP_REQ: state_d = ST_COMP_CHK;
			ST_COMP_CHK: state_d = ST_COMP_CHK;
			ST_UNION:    state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
		if (find_end) begin
			if (!side_q) begin
				state_d = ST_WALK_REQ;
			end else if (do_union) begin
				state_d = ST_UNION;
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	// RAM controls
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = {p_q, root_q};
		raddr = cur_q;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = {1'b0, cnt_q[AW-1:0]};
			end
			ST_WALK_CHK: begin
				// prefetch the next link while still walking
				if (!at_root) begin
					raddr = rd_node;
				end
			end
			ST_COMP_CHK: begin
				we    = 1'b1;
				waddr = cur_q;
				wdata = {p_q, root_q};
				if (!comp_last) begin
					raddr = rd_node;
				end
			end
			ST_UNION: begin
				we    = 1'b1;
				waddr = root_q;
				wdata = {pa_q ^ acc_q ^ 1'b1, ra_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			side_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
				end
				ST_IDLE: begin
					cnt_q  <= '0;
					side_q <= 1'b0;
					if (start) begin
						if (req.command == CMD_CLEAR) begin
							if (lim == '0) begin
								done_q <= 1'b1;
							end
						end else if (!(cmd_ok && in_range)) begin
							done_q <= 1'b1;
						end
					end
				end
				default: begin
					if (find_end) begin
						side_q <= 1'b1;
						if (side_q) begin
							done_q <= 1'b1;
						end
					end
				end
			endcase
			if ((state_q == ST_CLEAR) && clear_last) begin
				done_q <= 1'b1;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q    <= req.command;
				node_b_q <= AW'(req.node_b);
				node_q   <= AW'(req.node_a);
				cur_q    <= AW'(req.node_a);
				acc_q    <= 1'b0;
				rsp_q    <= '0;
				if (start && (req.command != CMD_CLEAR) && !(cmd_ok && in_range)) begin
					rsp_q.error <= 1'b1;
				end
			end
			ST_CLEAR: begin
				rsp_q <= '0;
			end
			ST_WALK_CHK: begin
				if (!at_root) begin
					acc_q <= acc_q ^ rd_par;
					cur_q <= rd_node;
				end else if (cur_q != node_q) begin
					root_q <= cur_q;
					p_q    <= acc_q;
					cur_q  <= node_q;
				end
			end
			ST_COMP_CHK: begin
				p_q   <= p_q ^ rd_par;
				cur_q <= rd_node;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
		if (find_end) begin
			if (!side_q) begin
				ra_q   <= fin_root;
				pa_q   <= acc_q;
				node_q <= node_b_q;
				cur_q  <= node_b_q;
				acc_q  <= 1'b0;
			end else begin
				// keep b's root and parity for the union write
				root_q         <= fin_root;
				rsp_q.root_a   <= NODE_W'(ra_q);
				rsp_q.parity_a <= pa_q;
				rsp_q.root_b   <= NODE_W'(fin_root);
				rsp_q.parity_b <= acc_q;
				rsp_q.same_set <= (ra_q == fin_root);
				rsp_q.error    <= 1'b0;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
